>>> design/kbn_pkg.sv
// Shared types and constants for the k-best neighbor list update core.
// Holds the command and result records and the field widths; no dependencies.
package kbn_pkg;

    localparam int LIST_SIZE_DEF = 20;
    localparam int QUEUE_DEPTH   = 2;

    localparam int CMD_W  = 2;
    localparam int SLOT_W = 5;
    localparam int IDX_W  = 10;
    localparam int DIST_W = 32;

    localparam logic [DIST_W-1:0] DIST_INF = '1;

    localparam logic [CMD_W-1:0] CMD_SEED  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OFFER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    typedef enum logic [1:0] {
        OP_SEED,
        OP_OFFER,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              slot_ok;
        logic [SLOT_W-1:0] slot;
        logic [IDX_W-1:0]  cidx;
        logic [DIST_W-1:0] cdist;
    } cmd_t;

    typedef struct packed {
        logic              changed;
        logic              was_present;
        logic [IDX_W-1:0]  read_index;
        logic [DIST_W-1:0] read_distance;
    } res_t;

endpackage

>>> design/kbn_fifo.sv
// Small register queue used between the front, the back and the result port.
// Depends on kbn_pkg for its default depth.
module kbn_fifo
    import kbn_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_en;
    logic             rd_en;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr_en = push && !full;
    assign rd_en = pop && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> design/kbn_front.sv
// Input side: takes commands, decodes them and checks the slot range.
// Depends on kbn_pkg and kbn_fifo, which holds decoded commands for the back end.
module kbn_front
    import kbn_pkg::*;
#(
    parameter int LIST_SIZE = LIST_SIZE_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CMD_W-1:0]  command,
    input  logic [SLOT_W-1:0] slot,
    input  logic [IDX_W-1:0]  candidate_index,
    input  logic [DIST_W-1:0] candidate_distance,
    output logic              cmd_valid,
    output cmd_t              cmd,
    input  logic              cmd_pop
);

    cmd_t                  cmd_in;
    logic [$bits(cmd_t)-1:0] cmd_q;
    logic                  cmd_empty;

    always_comb
    begin
        unique case (command)
            CMD_SEED:  cmd_in.op = OP_SEED;
            CMD_OFFER: cmd_in.op = OP_OFFER;
            CMD_READ:  cmd_in.op = OP_READ;
            default:   cmd_in.op = OP_NOP;
        endcase
        cmd_in.slot_ok = (int'(slot) < LIST_SIZE);
        cmd_in.slot    = slot;
        cmd_in.cidx    = candidate_index;
        cmd_in.cdist   = candidate_distance;
    end

    kbn_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_q),
        .empty (cmd_empty)
    );

    assign cmd_valid = !cmd_empty;
    assign cmd       = cmd_q;

endmodule

>>> design/kbn_back.sv
// Execution side: holds the neighbor list, serves seeds and reads, and runs offers
// through an odd-even transposition sort. Depends on kbn_pkg.
module kbn_back
    import kbn_pkg::*;
#(
    parameter int LIST_SIZE = LIST_SIZE_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_pop,
    input  logic res_full,
    output logic res_push,
    output res_t res
);

    localparam int N    = LIST_SIZE + 1;
    localparam int PH_W = $clog2(N);
    localparam int KEY_W = DIST_W + 2;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SORT   = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic              found_reg, found_next;

    logic [IDX_W-1:0]  list_idx_reg  [LIST_SIZE];
    logic [DIST_W-1:0] list_dist_reg [LIST_SIZE];

    logic [IDX_W-1:0]  w_idx_reg  [N];
    logic [DIST_W-1:0] w_dist_reg [N];
    logic              w_new_reg  [N];

    logic [IDX_W-1:0]  s_idx  [N];
    logic [DIST_W-1:0] s_dist [N];
    logic              s_new  [N];

    logic [LIST_SIZE-1:0] match;
    logic                 found;
    logic                 changed;
    logic [IDX_W-1:0]     rd_idx;
    logic [DIST_W-1:0]    rd_dist;
    logic                 load;
    logic                 step;
    logic                 commit;
    logic                 seed_we;

    always_comb
    begin
        for (int i = 0; i < LIST_SIZE; i++)
        begin
            match[i] = (list_idx_reg[i] == cmd.cidx);
        end
    end

    assign found = |match;

    always_comb
    begin
        rd_idx  = '0;
        rd_dist = DIST_INF;
        for (int i = 0; i < LIST_SIZE; i++)
        begin
            if (cmd.slot_ok && int'(cmd.slot) == i)
            begin
                rd_idx  = list_idx_reg[i];
                rd_dist = list_dist_reg[i];
            end
        end
    end

    always_comb
    begin
        changed = 1'b0;
        for (int i = 0; i < LIST_SIZE; i++)
        begin
            if (w_idx_reg[i] != list_idx_reg[i] || w_dist_reg[i] != list_dist_reg[i])
            begin
                changed = 1'b1;
            end
        end
    end

    // The extra entry at the end is dead when the candidate matched; it then
    // sorts last and falls off the list.
    always_comb
    begin
        logic [KEY_W-1:0] ka;
        logic [KEY_W-1:0] kb;
        for (int i = 0; i < N; i++)
        begin
            s_idx[i]  = w_idx_reg[i];
            s_dist[i] = w_dist_reg[i];
            s_new[i]  = w_new_reg[i];
        end
        for (int i = 0; i < N - 1; i++)
        begin
            ka = {1'b0, w_dist_reg[i], w_new_reg[i]};
            kb = {((i + 1 == LIST_SIZE) && found_reg), w_dist_reg[i + 1], w_new_reg[i + 1]};
            if (((i % 2) == int'(phase_reg[0])) && (ka > kb))
            begin
                s_idx[i]      = w_idx_reg[i + 1];
                s_dist[i]     = w_dist_reg[i + 1];
                s_new[i]      = w_new_reg[i + 1];
                s_idx[i + 1]  = w_idx_reg[i];
                s_dist[i + 1] = w_dist_reg[i];
                s_new[i + 1]  = w_new_reg[i];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        found_next = found_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        res        = '0;
        load       = 1'b0;
        step       = 1'b0;
        commit     = 1'b0;
        seed_we    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_OFFER:
                        begin
                            cmd_pop    = 1'b1;
                            load       = 1'b1;
                            found_next = found;
                            phase_next = '0;
                            state_next = ST_SORT;
                        end
                        OP_SEED:
                        begin
                            if (!res_full)
                            begin
                                cmd_pop  = 1'b1;
                                res_push = 1'b1;
                                seed_we  = cmd.slot_ok;
                            end
                        end
                        OP_READ:
                        begin
                            if (!res_full)
                            begin
                                cmd_pop           = 1'b1;
                                res_push          = 1'b1;
                                res.read_index    = rd_idx;
                                res.read_distance = rd_dist;
                            end
                        end
                        default:
                        begin
                            if (!res_full)
                            begin
                                cmd_pop  = 1'b1;
                                res_push = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_SORT:
            begin
                step = 1'b1;
                if (phase_reg == PH_W'(N - 1))
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    phase_next = phase_reg + 1'b1;
                end
            end
            ST_COMMIT:
            begin
                if (!res_full)
                begin
                    commit          = 1'b1;
                    res_push        = 1'b1;
                    res.changed     = changed;
                    res.was_present = found_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIST_SIZE; i++)
            begin
                list_idx_reg[i]  <= '0;
                list_dist_reg[i] <= DIST_INF;
            end
        end
        else
        begin
            for (int i = 0; i < LIST_SIZE; i++)
            begin
                if (commit)
                begin
                    list_idx_reg[i]  <= w_idx_reg[i];
                    list_dist_reg[i] <= w_dist_reg[i];
                end
                else if (seed_we && int'(cmd.slot) == i)
                begin
                    list_idx_reg[i]  <= cmd.cidx;
                    list_dist_reg[i] <= cmd.cdist;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < LIST_SIZE; i++)
            begin
                w_idx_reg[i]  <= list_idx_reg[i];
                w_dist_reg[i] <= match[i] ? cmd.cdist : list_dist_reg[i];
                w_new_reg[i]  <= match[i];
            end
            w_idx_reg[LIST_SIZE]  <= cmd.cidx;
            w_dist_reg[LIST_SIZE] <= cmd.cdist;
            w_new_reg[LIST_SIZE]  <= 1'b1;
        end
        else if (step)
        begin
            for (int i = 0; i < N; i++)
            begin
                w_idx_reg[i]  <= s_idx[i];
                w_dist_reg[i] <= s_dist[i];
                w_new_reg[i]  <= s_new[i];
            end
        end
    end

endmodule

>>> design/k_best_neighbor_list_update_core.sv
// Top level of the k-best neighbor list update core: command queue, execution
// back end and result queue. Depends on kbn_pkg, kbn_front, kbn_back and kbn_fifo.
//
//  Channel   Handshake      Payload
//  input     push / full    command, slot, candidate_index, candidate_distance
//  result    pop / empty    changed, was_present, read_index, read_distance
//
// Seed, read and unknown commands are answered straight from the idle state of the back end.
// An offer runs a load, LIST_SIZE + 1 sort phases of the odd-even transposition
// row, and a commit that waits for room in the result queue.
// Reset clears the list to index zero and infinite distance and empties both queues.
// The command queue keeps accepting while results wait, until it is full itself;
// a full result queue stalls the back end, which then stops taking commands.
module k_best_neighbor_list_update_core
    import kbn_pkg::*;
#(
    parameter int LIST_SIZE = LIST_SIZE_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CMD_W-1:0]  command,
    input  logic [SLOT_W-1:0] slot,
    input  logic [IDX_W-1:0]  candidate_index,
    input  logic [DIST_W-1:0] candidate_distance,
    output logic              empty,
    input  logic              pop,
    output logic              changed,
    output logic              was_present,
    output logic [IDX_W-1:0]  read_index,
    output logic [DIST_W-1:0] read_distance
);

    logic                    cmd_valid;
    cmd_t                    cmd;
    logic                    cmd_pop;
    logic                    res_full;
    logic                    res_push;
    res_t                    res_in;
    logic [$bits(res_t)-1:0] res_q;
    res_t                    res_out;

    kbn_front #(
        .LIST_SIZE (LIST_SIZE)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .command            (command),
        .slot               (slot),
        .candidate_index    (candidate_index),
        .candidate_distance (candidate_distance),
        .cmd_valid          (cmd_valid),
        .cmd                (cmd),
        .cmd_pop            (cmd_pop)
    );

    kbn_back #(
        .LIST_SIZE (LIST_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    kbn_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_q),
        .empty (empty)
    );

    assign res_out       = res_q;
    assign changed       = res_out.changed;
    assign was_present   = res_out.was_present;
    assign read_index    = res_out.read_index;
    assign read_distance = res_out.read_distance;

    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("back end took a command from an empty queue");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("back end wrote a result into a full queue");

    a_offer_not_immediate: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd.op == OP_OFFER) |=> !res_push)
        else $error("offer result issued before the sort ran");

endmodule

>>> test/k_best_neighbor_list_update_core_tb.sv
// Self-checking testbench for k_best_neighbor_list_update_core: directed and random
// seed, offer, read and unknown commands with a bit-exact list tracker and random idling.
// Depends on kbn_pkg and the k_best_neighbor_list_update_core design files.
module k_best_neighbor_list_update_core_tb;
    import kbn_pkg::*;

    localparam int LIST_LEN = LIST_SIZE_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 560;
    localparam int DRAIN_CYCLES = 64;

    typedef enum int {
        RX_STEADY,
        RX_JITTER,
        RX_BURSTY,
        RX_LONG
    } rx_pattern_t;

    class neighbor_list_tracker;
        logic [IDX_W-1:0]  rank_index[LIST_LEN];
        logic [DIST_W-1:0] rank_distance[LIST_LEN];
        res_t              awaited[$];
        int                errors;
        int                offers;
        int                reads;
        int                seeds;
        int                unknowns;
        int                changes;
        int                hits;

        function new();
            for (int i = 0; i < LIST_LEN; i++)
            begin
                rank_index[i] = '0;
                rank_distance[i] = DIST_INF;
            end
            errors = 0;
            offers = 0;
            reads = 0;
            seeds = 0;
            unknowns = 0;
            changes = 0;
            hits = 0;
        endfunction

        function void merge_offer(input logic [IDX_W-1:0] idx,
                                  input logic [DIST_W-1:0] cand_dist,
                                  output logic chg, output logic hit);
            logic [IDX_W-1:0]  seq_i[LIST_LEN+1];
            logic [DIST_W-1:0] seq_d[LIST_LEN+1];
            logic [IDX_W-1:0]  ki;
            logic [DIST_W-1:0] kd;
            int                n;
            int                j;
            n = 0;
            hit = 1'b0;
            chg = 1'b0;
            for (int i = 0; i < LIST_LEN; i++)
            begin
                if (rank_index[i] != idx)
                begin
                    seq_i[n] = rank_index[i];
                    seq_d[n] = rank_distance[i];
                    n++;
                end
                else
                begin
                    hit = 1'b1;
                end
            end
            if (hit)
            begin
                for (int i = 0; i < LIST_LEN; i++)
                begin
                    if (rank_index[i] == idx)
                    begin
                        seq_i[n] = idx;
                        seq_d[n] = cand_dist;
                        n++;
                    end
                end
            end
            else
            begin
                seq_i[n] = idx;
                seq_d[n] = cand_dist;
                n++;
            end
            for (int i = 1; i < n; i++)
            begin
                ki = seq_i[i];
                kd = seq_d[i];
                j = i - 1;
                while (j >= 0 && seq_d[j] > kd)
                begin
                    seq_i[j+1] = seq_i[j];
                    seq_d[j+1] = seq_d[j];
                    j--;
                end
                seq_i[j+1] = ki;
                seq_d[j+1] = kd;
            end
            for (int i = 0; i < LIST_LEN; i++)
            begin
                if (seq_i[i] != rank_index[i] || seq_d[i] != rank_distance[i])
                    chg = 1'b1;
                rank_index[i] = seq_i[i];
                rank_distance[i] = seq_d[i];
            end
        endfunction

        function void note_transfer(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] sl,
                                    logic [IDX_W-1:0] idx, logic [DIST_W-1:0] cand_dist);
            res_t r;
            r = '0;
            case (cmd)
                CMD_SEED:
                begin
                    seeds++;
                    if (sl < LIST_LEN)
                    begin
                        rank_index[sl] = idx;
                        rank_distance[sl] = cand_dist;
                    end
                end
                CMD_OFFER:
                begin
                    offers++;
                    merge_offer(idx, cand_dist, r.changed, r.was_present);
                    changes += r.changed;
                    hits += r.was_present;
                end
                CMD_READ:
                begin
                    reads++;
                    if (sl < LIST_LEN)
                    begin
                        r.read_index = rank_index[sl];
                        r.read_distance = rank_distance[sl];
                    end
                    else
                    begin
                        r.read_distance = DIST_INF;
                    end
                end
                default:
                    unknowns++;
            endcase
            awaited.insert(awaited.size(), r);
        endfunction

        function void match_result(res_t got);
            res_t want;
            if (awaited.size() == 0)
            begin
                $error("result transfer with no expected result waiting");
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.changed !== want.changed)
            begin
                $error("changed: expected %0d, actual %0d", want.changed, got.changed);
                errors++;
            end
            if (got.was_present !== want.was_present)
            begin
                $error("was_present: expected %0d, actual %0d", want.was_present,
                       got.was_present);
                errors++;
            end
            if (got.read_index !== want.read_index)
            begin
                $error("read_index: expected %0d, actual %0d", want.read_index,
                       got.read_index);
                errors++;
            end
            if (got.read_distance !== want.read_distance)
            begin
                $error("read_distance: expected %h, actual %h", want.read_distance,
                       got.read_distance);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [CMD_W-1:0]  command = '0;
    logic [SLOT_W-1:0] slot = '0;
    logic [IDX_W-1:0]  candidate_index = '0;
    logic [DIST_W-1:0] candidate_distance = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic              changed;
    logic              was_present;
    logic [IDX_W-1:0]  read_index;
    logic [DIST_W-1:0] read_distance;

    neighbor_list_tracker sb;
    res_t                 seen;
    int                   cycle_count = 0;
    int                   burst_left = 0;
    rx_pattern_t          rx_mode = RX_STEADY;
    int                   rx_timer = 0;
    int                   rx_stall = 0;

    k_best_neighbor_list_update_core #(
        .LIST_SIZE(LIST_LEN)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .command(command),
        .slot(slot),
        .candidate_index(candidate_index),
        .candidate_distance(candidate_distance),
        .empty(empty),
        .pop(pop),
        .changed(changed),
        .was_present(was_present),
        .read_index(read_index),
        .read_distance(read_distance)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("k_best_neighbor_list_update_core_tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            seen.changed = changed;
            seen.was_present = was_present;
            seen.read_index = read_index;
            seen.read_distance = read_distance;
            sb.match_result(seen);
        end
        if (rx_timer == 0)
        begin
            rx_mode = rx_pattern_t'($urandom_range(0, 3));
            rx_timer = $urandom_range(50, 300);
        end
        else
        begin
            rx_timer--;
        end
        if (rx_stall > 0)
        begin
            rx_stall--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
            case (rx_mode)
                RX_JITTER: if ($urandom_range(0, 9) < 3) rx_stall = $urandom_range(1, 3);
                RX_BURSTY: if ($urandom_range(0, 15) == 0) rx_stall = 12;
                RX_LONG:   if ($urandom_range(0, 31) == 0) rx_stall = $urandom_range(10, 40);
                default:   ;
            endcase
        end
    end

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] sl,
                             logic [IDX_W-1:0] idx, logic [DIST_W-1:0] cand_dist);
        push <= 1'b1;
        command <= cmd;
        slot <= sl;
        candidate_index <= idx;
        candidate_distance <= cand_dist;
        do
            @(posedge clk);
        while (full);
        sb.note_transfer(cmd, sl, idx, cand_dist);
    endtask

    task automatic send_paced(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] sl,
                              logic [IDX_W-1:0] idx, logic [DIST_W-1:0] cand_dist);
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
        end
        burst_left--;
        send_item(cmd, sl, idx, cand_dist);
    endtask

    task automatic drain();
        push <= 1'b0;
        do
            @(posedge clk);
        while (sb.awaited.size() != 0);
        burst_left = 0;
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        case ($urandom_range(0, 9))
            7, 8:    return IDX_W'($urandom_range(0, 1023));
            9:       return $urandom_range(0, 1) ? 10'd0 : 10'd1023;
            default: return IDX_W'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [DIST_W-1:0] pick_distance();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DIST_INF;
            2:       return DIST_INF - $urandom_range(1, 4);
            3, 4, 5: return {5'd0, 3'($urandom_range(0, 7)), 24'd0};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_item();
        int                pick;
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] sl;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            cmd = CMD_OFFER;
        else if (pick < 80)
            cmd = CMD_READ;
        else if (pick < 95)
            cmd = CMD_SEED;
        else
            cmd = CMD_UNUSED;
        sl = ($urandom_range(0, 6) == 0) ? SLOT_W'($urandom_range(LIST_LEN, 31))
                                         : SLOT_W'($urandom_range(0, LIST_LEN - 1));
        send_paced(cmd, sl, pick_index(), pick_distance());
    endtask

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_paced(CMD_READ, 5'd0, '0, '0);
        send_paced(CMD_READ, 5'd19, '1, '1);
        send_paced(CMD_READ, 5'd31, '0, '0);
        send_paced(CMD_OFFER, 5'd0, 10'd0, 32'd5);
        send_paced(CMD_OFFER, 5'd0, 10'd1023, 32'd0);
        send_paced(CMD_SEED, 5'd19, 10'd512, 32'd0);
        send_paced(CMD_SEED, 5'd25, 10'd7, 32'd7);
        send_paced(CMD_SEED, 5'd31, 10'd1023, DIST_INF);
        send_paced(CMD_OFFER, 5'd0, 10'd1023, 32'd0);
        send_paced(CMD_OFFER, 5'd0, 10'd300, DIST_INF);
        send_paced(CMD_OFFER, 5'd0, 10'd0, 32'd5);
        send_paced(CMD_UNUSED, 5'd31, 10'd1023, DIST_INF);
        send_paced(CMD_READ, 5'd0, '0, '0);
        send_paced(CMD_READ, 5'd1, '0, '0);
        send_paced(CMD_READ, 5'd19, '0, '0);
        send_paced(CMD_SEED, 5'd0, 10'd9, 32'h8000_0000);
        send_paced(CMD_SEED, 5'd1, 10'd9, 32'h0000_0001);
        send_paced(CMD_OFFER, 5'd0, 10'd9, 32'h7FFF_FFFF);
        send_paced(CMD_OFFER, 5'd0, 10'd44, 32'hFFFF_FFFE);
        send_paced(CMD_OFFER, 5'd0, 10'd45, 32'h7FFF_FFFF);
        send_paced(CMD_READ, 5'd19, '0, '0);
        send_paced(CMD_READ, 5'd20, '0, '0);
        drain();

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 160 == 80)
            begin
                for (int s = 0; s < LIST_LEN; s++)
                    send_paced(CMD_SEED, SLOT_W'(s), pick_index(),
                               (k % 320 == 80) ? {3'(s), 29'd0} : pick_distance());
            end
            if (k == RANDOM_ITEMS / 2)
                drain();
            send_random_item();
        end
        push <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d offers (%0d changed, %0d already present), %0d reads,",
                 sb.offers, sb.changes, sb.hits, sb.reads);
        $display("%0d seeds and %0d unknown commands under random idling on both sides.",
                 sb.seeds, sb.unknowns);
        if (sb.errors == 0)
            $display("k_best_neighbor_list_update_core_tb passed");
        else
            $display("k_best_neighbor_list_update_core_tb failed");
        $finish;
    end
endmodule
